FILE: rtl/core/tsf_pkg.sv
package tsf_pkg;

    // Field widths
    localparam int unsigned RANGE_W  = 16;
    localparam int unsigned RAW_W    = 32;
    localparam int unsigned MM_W     = 15;
    localparam int unsigned SEQ_W    = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Item actions
    localparam logic ACTION_TARGET = 1'b0;
    localparam logic ACTION_CLOSE  = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SIGNAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SIGMA    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RELIABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OOR_CODE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP     = 3'd4;

    // Register reset values
    localparam logic [RAW_W-1:0] MIN_SIGNAL_RST   = 32'd19660;   // 0.3 Mcps
    localparam logic [RAW_W-1:0] MAX_SIGMA_RST    = 32'd1310720; // 20 mm
    localparam logic [MM_W-1:0]  MAX_RELIABLE_RST = 15'd4000;
    localparam logic [MM_W-1:0]  OOR_CODE_RST     = 15'd8191;
    localparam logic [MM_W-1:0]  MAX_STEP_RST     = 15'd200;

    // Range value meaning "no target kept"
    localparam logic signed [RANGE_W-1:0] NO_RANGE = -16'sd1;

    typedef struct packed {
        logic [RAW_W-1:0] min_signal_raw;
        logic [RAW_W-1:0] max_sigma_raw;
        logic [MM_W-1:0]  max_reliable_mm;
        logic [MM_W-1:0]  out_of_range_code;
        logic [MM_W-1:0]  max_step_mm;
    } cfg_t;

    typedef struct packed {
        logic                      action;
        logic signed [RANGE_W-1:0] range_mm;
        logic                      status_valid;
        logic [RAW_W-1:0]          signal_raw;
        logic [RAW_W-1:0]          sigma_raw;
        logic                      data_read_ok;
        logic                      restart_ok;
    } item_t;

endpackage

FILE: rtl/core/tsf_if.sv
// Configuration write channel
interface tsf_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tsf_pkg::CFG_IDX_W-1:0]      index;
    logic [tsf_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// Target / close item channel
interface tsf_item_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 action;
    logic signed [tsf_pkg::RANGE_W-1:0]   range_mm;
    logic                                 status_valid;
    logic [tsf_pkg::RAW_W-1:0]            signal_raw;
    logic [tsf_pkg::RAW_W-1:0]            sigma_raw;
    logic                                 data_read_ok;
    logic                                 restart_ok;

    modport source (output valid, output action, output range_mm, output status_valid,
                    output signal_raw, output sigma_raw, output data_read_ok,
                    output restart_ok, input ready);
    modport sink   (input valid, input action, input range_mm, input status_valid,
                    input signal_raw, input sigma_raw, input data_read_ok,
                    input restart_ok, output ready);
endinterface

// Result channel
interface tsf_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tsf_pkg::RANGE_W-1:0]   distance_out_mm;
    logic signed [tsf_pkg::RANGE_W-1:0]   kept_range_out_mm;
    logic [tsf_pkg::RAW_W-1:0]            signal_out;
    logic [tsf_pkg::RAW_W-1:0]            sigma_out;
    logic                                 target_found;
    logic                                 bus_failed;
    logic [tsf_pkg::SEQ_W-1:0]            sequence_res;

    modport source (output valid, output distance_out_mm, output kept_range_out_mm,
                    output signal_out, output sigma_out, output target_found,
                    output bus_failed, output sequence_res, input ready);
    modport sink   (input valid, input distance_out_mm, input kept_range_out_mm,
                    input signal_out, input sigma_out, input target_found,
                    input bus_failed, input sequence_res, output ready);
endinterface

FILE: rtl/core/tsf_cfg_regs.sv
module tsf_cfg_regs
(
    input  logic              clk,
    input  logic              rst_n,
    tsf_cfg_if.sink           cfg,
    output tsf_pkg::cfg_t     cfg_q
);

    tsf_pkg::cfg_t cfg_reg;

    // Writes are always taken
    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    // Register file; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_signal_raw    <= tsf_pkg::MIN_SIGNAL_RST;
            cfg_reg.max_sigma_raw     <= tsf_pkg::MAX_SIGMA_RST;
            cfg_reg.max_reliable_mm   <= tsf_pkg::MAX_RELIABLE_RST;
            cfg_reg.out_of_range_code <= tsf_pkg::OOR_CODE_RST;
            cfg_reg.max_step_mm       <= tsf_pkg::MAX_STEP_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                tsf_pkg::REG_MIN_SIGNAL:   cfg_reg.min_signal_raw    <= cfg.data;
                tsf_pkg::REG_MAX_SIGMA:    cfg_reg.max_sigma_raw     <= cfg.data;
                tsf_pkg::REG_MAX_RELIABLE: cfg_reg.max_reliable_mm   <= cfg.data[tsf_pkg::MM_W-1:0];
                tsf_pkg::REG_OOR_CODE:     cfg_reg.out_of_range_code <= cfg.data[tsf_pkg::MM_W-1:0];
                tsf_pkg::REG_MAX_STEP:     cfg_reg.max_step_mm       <= cfg.data[tsf_pkg::MM_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/core/tsf_in_stage.sv
module tsf_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    tsf_item_if.sink          items,
    input  logic              advance,
    output tsf_pkg::item_t    item,
    output logic              item_valid
);

    tsf_pkg::item_t item_reg;
    logic           valid_reg;
    logic           load;

    // Take a new item when empty or when the held one moves on
    assign items.ready = !valid_reg || advance;
    assign load        = items.valid && items.ready;
    assign item        = item_reg;
    assign item_valid  = valid_reg;

    // Occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (items.ready)
        begin
            valid_reg <= items.valid;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.action       <= items.action;
            item_reg.range_mm     <= items.range_mm;
            item_reg.status_valid <= items.status_valid;
            item_reg.signal_raw   <= items.signal_raw;
            item_reg.sigma_raw    <= items.sigma_raw;
            item_reg.data_read_ok <= items.data_read_ok;
            item_reg.restart_ok   <= items.restart_ok;
        end
    end

endmodule

FILE: rtl/core/tsf_core.sv
module tsf_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  tsf_pkg::cfg_t     cfg_q,
    input  tsf_pkg::item_t    item,
    input  logic              item_valid,
    output logic              advance,
    tsf_result_if.source      results
);

    localparam int unsigned MM_W = tsf_pkg::MM_W;

    // Measurement state
    logic signed [tsf_pkg::RANGE_W-1:0] best_range_reg;
    logic [tsf_pkg::RAW_W-1:0]          best_signal_reg;
    logic [tsf_pkg::RAW_W-1:0]          best_sigma_reg;
    logic                               prev_valid_reg;
    logic [MM_W-1:0]                    prev_reg;
    logic [tsf_pkg::SEQ_W-1:0]          count_reg;
    logic [tsf_pkg::SEQ_W-1:0]          count_next;

    // Result register
    logic                               res_valid_reg;
    logic [MM_W-1:0]                    res_dist_reg;
    logic signed [tsf_pkg::RANGE_W-1:0] res_raw_reg;
    logic [tsf_pkg::RAW_W-1:0]          res_signal_reg;
    logic [tsf_pkg::RAW_W-1:0]          res_sigma_reg;
    logic                               res_found_reg;
    logic                               res_bus_failed_reg;
    logic [tsf_pkg::SEQ_W-1:0]          res_seq_reg;

    logic            is_close;
    logic            do_target;
    logic            do_close;
    logic            keep;
    logic            found;
    logic [MM_W-1:0] dist_sel;
    logic [MM_W-1:0] dist_clamp;
    logic            slew_on;
    logic [MM_W:0]   prev_up;
    logic [MM_W:0]   dist_up;
    logic [MM_W-1:0] dist_next;

    // Targets never wait on the result side; a close needs a free result slot
    assign is_close  = (item.action == tsf_pkg::ACTION_CLOSE);
    assign advance   = item_valid && (!is_close || !res_valid_reg || results.ready);
    assign do_target = advance && !is_close;
    assign do_close  = advance && is_close;

    // Target acceptance: strictly farther than the kept one (kept is -1 when empty)
    assign keep = item.status_valid
               && (item.signal_raw > cfg_q.min_signal_raw)
               && (item.sigma_raw < cfg_q.max_sigma_raw)
               && (item.range_mm > best_range_reg);

    // Close: pick distance; above the reliable limit use the out-of-range code
    assign found      = item.data_read_ok && !best_range_reg[tsf_pkg::RANGE_W-1];
    assign dist_sel   = found ? best_range_reg[MM_W-1:0] : cfg_q.out_of_range_code;
    assign dist_clamp = (dist_sel > cfg_q.max_reliable_mm) ? cfg_q.out_of_range_code
                                                           : dist_sel;

    // Slew limit against the previous in-range distance
    assign slew_on = (dist_clamp != cfg_q.out_of_range_code) && prev_valid_reg
                  && (prev_reg != cfg_q.out_of_range_code);
    assign prev_up = {1'b0, prev_reg} + {1'b0, cfg_q.max_step_mm};
    assign dist_up = {1'b0, dist_clamp} + {1'b0, cfg_q.max_step_mm};

    always_comb
    begin
        dist_next = dist_clamp;
        if (slew_on)
        begin
            priority if ({1'b0, dist_clamp} > prev_up)
                dist_next = prev_up[MM_W-1:0];
            else if (dist_up < {1'b0, prev_reg})
                dist_next = prev_reg - cfg_q.max_step_mm;
            else
                dist_next = dist_clamp;
        end
    end

    assign count_next = count_reg + {{(tsf_pkg::SEQ_W-1){1'b0}}, 1'b1};

    // Kept target, previous distance and sequence count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_range_reg  <= tsf_pkg::NO_RANGE;
            best_signal_reg <= '0;
            best_sigma_reg  <= '0;
            prev_valid_reg  <= 1'b0;
            prev_reg        <= '0;
            count_reg       <= '0;
        end
        else if (do_close)
        begin
            best_range_reg  <= tsf_pkg::NO_RANGE;
            best_signal_reg <= '0;
            best_sigma_reg  <= '0;
            prev_valid_reg  <= 1'b1;
            prev_reg        <= dist_next;
            count_reg       <= count_next;
        end
        else if (do_target && keep)
        begin
            best_range_reg  <= item.range_mm;
            best_signal_reg <= item.signal_raw;
            best_sigma_reg  <= item.sigma_raw;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (do_close)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (do_close)
        begin
            res_dist_reg       <= dist_next;
            res_raw_reg        <= found ? best_range_reg : tsf_pkg::NO_RANGE;
            res_signal_reg     <= found ? best_signal_reg : '0;
            res_sigma_reg      <= found ? best_sigma_reg : '0;
            res_found_reg      <= found;
            res_bus_failed_reg <= !item.restart_ok;
            res_seq_reg        <= count_next;
        end
    end

    assign results.valid             = res_valid_reg;
    assign results.distance_out_mm   = {1'b0, res_dist_reg};
    assign results.kept_range_out_mm = res_raw_reg;
    assign results.signal_out        = res_signal_reg;
    assign results.sigma_out         = res_sigma_reg;
    assign results.target_found      = res_found_reg;
    assign results.bus_failed        = res_bus_failed_reg;
    assign results.sequence_res      = res_seq_reg;

endmodule

FILE: rtl/core/tof_target_select_slew_filter.sv
// Farthest-target select with range clamp and slew limiting.
// Channels: cfg writes one of five registers by index (always ready, one
// transfer per cycle); items carries targets (action 0) and measurement
// closes (action 1); results carries one item per close.
// Each target transfer is compared against the kept target; a close picks
// the kept range (or the out-of-range code), replaces a range above the
// reliable limit by the out-of-range code, slew-limits it against the
// previous in-range distance and clears the kept target.
// Throughput: one item per cycle while no close waits on a held result;
// the single compare/clamp stage lies between the input register and the
// result register. A close is registered in the input register and then
// in the result register, from which its result transfers.
// Stall: the result register holds while results.ready is low; targets keep
// flowing, and a following close waits in the input register.
// Reset: registers return to defaults, the kept target and previous distance
// are cleared and the sequence count restarts at zero.
module tof_target_select_slew_filter
(
    input  logic        clk,
    input  logic        rst_n,
    tsf_cfg_if.sink     cfg,
    tsf_item_if.sink    items,
    tsf_result_if.source results
);

    tsf_pkg::cfg_t  cfg_q;
    tsf_pkg::item_t item;
    logic           item_valid;
    logic           advance;

    tsf_cfg_regs u_cfg_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    tsf_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .advance    (advance),
        .item       (item),
        .item_valid (item_valid)
    );

    tsf_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_q      (cfg_q),
        .item       (item),
        .item_valid (item_valid),
        .advance    (advance),
        .results    (results)
    );

endmodule
